>>> src/pdp_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and arithmetic helpers of the path data point parser.
package pdp_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned COORD_W        = 16;
    localparam int unsigned INDEX_W        = 6;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic [COORD_W-1:0]        MAG_MAX   = 16'hFFFF;
    localparam logic [COORD_W-1:0]        MAG_NEG_LIMIT = 16'h8000;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_H  = 8'h48;
    localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_UP_V  = 8'h56;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
    localparam logic [CHAR_W-1:0] CH_LO_L  = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_LO_M  = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_LO_V  = 8'h76;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_SEP     = 8'b0000_0010,
        PH_DISCARD = 8'b0000_0100,
        PH_PRE     = 8'b0000_1000,
        PH_INT     = 8'b0001_0000,
        PH_MID     = 8'b0010_0000,
        PH_ZPEND   = 8'b0100_0000,
        PH_FULL    = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        CMD_LINE_X  = 3'd0,
        CMD_RLINE_X = 3'd1,
        CMD_HORZ    = 3'd2,
        CMD_RHORZ   = 3'd3,
        CMD_VERT    = 3'd4,
        CMD_RVERT   = 3'd5,
        CMD_LINE_Y  = 3'd6,
        CMD_RLINE_Y = 3'd7
    } t_cmd;

    typedef struct packed {
        t_phase                     phase;
        t_cmd                       command;
        logic signed [COORD_W-1:0]  cur_x;
        logic signed [COORD_W-1:0]  cur_y;
        logic signed [COORD_W-1:0]  first_x;
        logic signed [COORD_W-1:0]  first_y;
        logic signed [COORD_W-1:0]  first_number;
        logic [COORD_W-1:0]         number_value;
        logic                       negative;
        logic                       in_fraction;
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [INDEX_W-1:0]         point_index;
        logic                       list_full;
    } t_point;

    localparam t_state STATE_RESET = '{phase: PH_START, command: CMD_LINE_X, default: '0};

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return c inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
    endfunction

    // Magnitude times ten plus the new digit, held at the largest magnitude.
    function automatic logic [COORD_W-1:0] acc_digit(input logic [COORD_W-1:0] mag,
                                                     input logic [CHAR_W-1:0]  c);
        logic [COORD_W+3:0] wide;
        logic [COORD_W+3:0] sum;
        wide = {4'b0000, mag};
        sum  = (wide << 3) + (wide << 1) + {{(COORD_W){1'b0}}, c[3:0]};
        return (sum > {4'b0000, MAG_MAX}) ? MAG_MAX : sum[COORD_W-1:0];
    endfunction

    // Signed coordinate from sign and magnitude, clamped to the 16-bit range.
    function automatic logic signed [COORD_W-1:0] to_coord(input logic [COORD_W-1:0] mag,
                                                          input logic               neg);
        logic signed [COORD_W-1:0] r;
        if (neg) begin
            r = (mag > MAG_NEG_LIMIT) ? COORD_MIN : $signed(~mag + 16'd1);
        end else begin
            r = mag[COORD_W-1] ? COORD_MAX : $signed(mag);
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] a,
                                                         input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0]   s;
        logic signed [COORD_W-1:0] r;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            r = s[COORD_W] ? COORD_MIN : COORD_MAX;
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    // The second half of a line command: the one that reads y.
    function automatic t_cmd to_y_cmd(input t_cmd c);
        return (c == CMD_RLINE_X) ? CMD_RLINE_Y : CMD_LINE_Y;
    endfunction

endpackage

>>> src/pdp_step.sv
`timescale 1ns / 1ps
// Next-state and point logic of the parser for one byte of path data.
module pdp_step #(
    parameter int unsigned MAX_POINTS = pdp_pkg::MAX_POINTS_DEF
) (
    input  pdp_pkg::t_state                     i_state,
    input  logic [$clog2(MAX_POINTS+1)-1:0]     i_points_made,
    input  logic [pdp_pkg::CHAR_W-1:0]          i_ch,
    input  logic                                i_last,
    output pdp_pkg::t_state                     o_state,
    output logic [$clog2(MAX_POINTS+1)-1:0]     o_points_made,
    output logic                                o_emit,
    output pdp_pkg::t_point                     o_point
);
    import pdp_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

    logic c_blank, c_digit, c_letter, c_minus, c_dot, c_comma;
    logic let_known, let_close;
    t_cmd let_cmd;

    logic [CntW-1:0] pm_inc;
    logic            fill;
    logic            pm_zero;

    logic signed [COORD_W-1:0] v_in;
    logic signed [COORD_W-1:0] v_last;

    // Working copies of the state as the byte is consumed.
    t_phase                    ph;
    t_cmd                      cmd;
    logic [COORD_W-1:0]        num;
    logic                      neg;
    logic                      frac;
    logic signed [COORD_W-1:0] fnum;
    logic                      em;
    logic                      done;
    logic                      do_fin;
    logic                      post_emit;
    logic                      take_let;
    logic                      z_go;
    t_cmd                      f_cmd;
    logic signed [COORD_W-1:0] f_fn;
    logic signed [COORD_W-1:0] f_v;

    logic signed [COORD_W-1:0] add_x, add_y;
    logic signed [COORD_W-1:0] nx, ny;
    logic signed [COORD_W-1:0] pt_x, pt_y;

    assign c_blank  = is_blank(i_ch);
    assign c_digit  = is_digit(i_ch);
    assign c_letter = is_letter(i_ch);
    assign c_minus  = (i_ch == CH_MINUS);
    assign c_dot    = (i_ch == CH_DOT);
    assign c_comma  = (i_ch == CH_COMMA);

    assign pm_inc  = i_points_made + CntW'(1);
    assign fill    = (pm_inc == CntW'(MAX_POINTS));
    assign pm_zero = (i_points_made == '0);

    // Value of the number held in the state, for a number that this byte ends.
    assign v_in = to_coord(i_state.number_value, i_state.negative);

    always_comb begin
        let_known = 1'b1;
        let_close = 1'b0;
        let_cmd   = CMD_LINE_X;
        case (i_ch)
            CH_UP_M, CH_UP_L: let_cmd = CMD_LINE_X;
            CH_LO_M, CH_LO_L: let_cmd = CMD_RLINE_X;
            CH_UP_H:          let_cmd = CMD_HORZ;
            CH_LO_H:          let_cmd = CMD_RHORZ;
            CH_UP_V:          let_cmd = CMD_VERT;
            CH_LO_V:          let_cmd = CMD_RVERT;
            CH_UP_Z, CH_LO_Z: begin
                let_known = 1'b0;
                let_close = 1'b1;
            end
            default:          let_known = 1'b0;
        endcase
    end

    always_comb begin
        ph        = i_state.phase;
        cmd       = i_state.command;
        num       = i_state.number_value;
        neg       = i_state.negative;
        frac      = i_state.in_fraction;
        fnum      = i_state.first_number;
        em        = 1'b0;
        done      = 1'b0;
        do_fin    = 1'b0;
        post_emit = 1'b0;
        take_let  = 1'b0;
        z_go      = 1'b0;
        f_cmd     = cmd;
        f_fn      = fnum;
        f_v       = '0;
        v_last    = '0;

        // A close-path held back from the previous byte goes out first.
        if (ph == PH_ZPEND) begin
            z_go = 1'b1;
            em   = 1'b1;
            ph   = fill ? PH_FULL : PH_SEP;
        end

        if (ph == PH_FULL) begin
            done = 1'b1;
        end

        if (!done && ph == PH_SEP) begin
            if (c_blank || c_comma) begin
                done = 1'b1;
            end else begin
                ph = PH_START;
            end
        end

        if (!done && ph == PH_START) begin
            if (c_letter) begin
                take_let = 1'b1;
                done     = 1'b1;
            end else if (c_digit || c_minus || c_dot || c_comma) begin
                cmd = CMD_LINE_X;
                ph  = PH_PRE;
            end else begin
                done = 1'b1;
            end
        end

        if (!done && ph == PH_DISCARD) begin
            if (!c_blank) begin
                ph = PH_START;
            end
            done = 1'b1;
        end

        if (!done && ph == PH_MID) begin
            if (c_blank || c_comma) begin
                done = 1'b1;
            end else begin
                ph = PH_PRE;
            end
        end

        if (!done && ph == PH_PRE) begin
            if (c_blank) begin
                done = 1'b1;
            end else if (c_minus) begin
                neg  = 1'b1;
                ph   = PH_INT;
                done = 1'b1;
            end else if (c_dot) begin
                frac = 1'b1;
                ph   = PH_INT;
                done = 1'b1;
            end else if (c_digit) begin
                ph = PH_INT;
            end else begin
                do_fin = 1'b1;
            end
        end

        if (!done && !do_fin && ph == PH_INT) begin
            if (c_digit) begin
                if (!frac) begin
                    num = acc_digit(num, i_ch);
                end
                done = 1'b1;
            end else if (c_dot && !frac) begin
                frac = 1'b1;
                done = 1'b1;
            end else begin
                do_fin = 1'b1;
            end
        end

        // The byte ends a number. The byte that ends a number is never a digit.
        if (do_fin) begin
            num  = '0;
            neg  = 1'b0;
            frac = 1'b0;
            if (cmd inside {CMD_LINE_X, CMD_RLINE_X}) begin
                fnum = v_in;
                cmd  = to_y_cmd(cmd);
                ph   = PH_MID;
                if (c_minus) begin
                    neg = 1'b1;
                    ph  = PH_INT;
                end else if (c_dot) begin
                    frac = 1'b1;
                    ph   = PH_INT;
                end else if (!(c_blank || c_comma)) begin
                    // A letter or stray byte completes the pair with y of zero.
                    f_cmd     = cmd;
                    f_fn      = fnum;
                    f_v       = '0;
                    post_emit = 1'b1;
                end
            end else begin
                f_cmd     = cmd;
                f_fn      = fnum;
                f_v       = v_in;
                post_emit = 1'b1;
            end
        end

        if (post_emit) begin
            cmd = CMD_LINE_X;
            em  = 1'b1;
            if (fill) begin
                ph = PH_FULL;
            end else if (c_blank || c_comma) begin
                ph = PH_SEP;
            end else if (c_minus) begin
                neg = 1'b1;
                ph  = PH_INT;
            end else if (c_dot) begin
                frac = 1'b1;
                ph   = PH_INT;
            end else if (c_letter) begin
                take_let = 1'b1;
            end else begin
                ph = PH_START;
            end
        end

        if (take_let) begin
            if (let_close) begin
                if (em) begin
                    ph = PH_ZPEND;
                end else begin
                    z_go = 1'b1;
                    em   = 1'b1;
                    ph   = fill ? PH_FULL : PH_SEP;
                end
            end else if (let_known) begin
                cmd = let_cmd;
                ph  = PH_PRE;
            end else begin
                ph = PH_DISCARD;
            end
        end

        // On the final byte an open command completes with missing numbers as zero.
        if (i_last && !em && (ph inside {PH_PRE, PH_INT, PH_MID})) begin
            v_last = to_coord(num, neg);
            em     = 1'b1;
            if (cmd inside {CMD_LINE_X, CMD_RLINE_X}) begin
                f_cmd = to_y_cmd(cmd);
                f_fn  = v_last;
                f_v   = '0;
            end else begin
                f_cmd = cmd;
                f_fn  = fnum;
                f_v   = v_last;
            end
        end
    end

    assign add_x = sat_add(i_state.cur_x, (f_cmd == CMD_RHORZ) ? f_v : f_fn);
    assign add_y = sat_add(i_state.cur_y, f_v);

    always_comb begin
        nx = i_state.cur_x;
        ny = i_state.cur_y;
        case (f_cmd)
            CMD_HORZ:    nx = f_v;
            CMD_RHORZ:   nx = add_x;
            CMD_VERT:    ny = f_v;
            CMD_RVERT:   ny = add_y;
            CMD_LINE_Y: begin
                nx = f_fn;
                ny = f_v;
            end
            CMD_RLINE_Y: begin
                nx = add_x;
                ny = add_y;
            end
            default: begin
                nx = i_state.cur_x;
                ny = i_state.cur_y;
            end
        endcase
    end

    // A close-path returns to the first point once there is one.
    always_comb begin
        if (z_go) begin
            pt_x = pm_zero ? i_state.cur_x : i_state.first_x;
            pt_y = pm_zero ? i_state.cur_y : i_state.first_y;
        end else begin
            pt_x = nx;
            pt_y = ny;
        end
    end

    always_comb begin
        o_state              = i_state;
        o_state.phase        = ph;
        o_state.command      = cmd;
        o_state.number_value = num;
        o_state.negative     = neg;
        o_state.in_fraction  = frac;
        o_state.first_number = fnum;
        if (em) begin
            o_state.cur_x = pt_x;
            o_state.cur_y = pt_y;
        end
        if (em && pm_zero) begin
            o_state.first_x = pt_x;
            o_state.first_y = pt_y;
        end
        o_points_made = em ? pm_inc : i_points_made;
        if (i_last) begin
            o_state       = STATE_RESET;
            o_points_made = '0;
        end
    end

    assign o_emit              = em;
    assign o_point.x           = pt_x;
    assign o_point.y           = pt_y;
    assign o_point.point_index = INDEX_W'(i_points_made);
    assign o_point.list_full   = fill;

endmodule

>>> src/path_data_point_parser.sv
`timescale 1ns / 1ps
// Top level of the path data point parser: input register, parser state and point register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | into      | i_in_valid / o_in_ready    | i_ch, i_last
//  out     | out of    | o_out_valid / i_out_ready  | o_x, o_y, o_point_index, o_list_full
//
// One byte is taken per cycle while the point register is empty or being taken. A byte is
// registered on transfer in the input register and parsed from there; a point that it completes
// is registered in the point register, from which it is presented and transferred on the output.
// The rate is set by the combinational parser update, which carries all state from byte to byte.
// Reset is synchronous and active low; it returns the parser to the start of new path data.
// When the point register is full and not taken, a byte in the input register holds and ready falls.
module path_data_point_parser #(
    parameter int unsigned MAX_POINTS = pdp_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pdp_pkg::CHAR_W-1:0]          i_ch,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pdp_pkg::COORD_W-1:0]  o_x,
    output logic signed [pdp_pkg::COORD_W-1:0]  o_y,
    output logic [pdp_pkg::INDEX_W-1:0]         o_point_index,
    output logic                                o_list_full
);
    import pdp_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_ch;
    logic              r_last;

    t_state            r_state;
    t_state            n_state;
    logic [CntW-1:0]   r_points_made;
    logic [CntW-1:0]   n_points_made;

    logic              r_out_valid;
    t_point            r_point;
    t_point            n_point;
    logic              step_emit;

    logic              out_free;
    logic              advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    pdp_step #(
        .MAX_POINTS (MAX_POINTS)
    ) u_step (
        .i_state       (r_state),
        .i_points_made (r_points_made),
        .i_ch          (r_ch),
        .i_last        (r_last),
        .o_state       (n_state),
        .o_points_made (n_points_made),
        .o_emit        (step_emit),
        .o_point       (n_point)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= STATE_RESET;
            r_points_made <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state       <= n_state;
                r_points_made <= n_points_made;
            end
            if (out_free) begin
                r_out_valid <= advance && step_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (advance && step_emit) begin
            r_point <= n_point;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_x           = r_point.x;
    assign o_y           = r_point.y;
    assign o_point_index = r_point.point_index;
    assign o_list_full   = r_point.list_full;

endmodule

>>> src/pdp_checker.sv
`timescale 1ns / 1ps
// Port checker of the path data point parser and its bind to the top level.
module pdp_checker #(
    parameter int unsigned MAX_POINTS = pdp_pkg::MAX_POINTS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [pdp_pkg::CHAR_W-1:0]          i_ch,
    input logic                                i_last,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [pdp_pkg::COORD_W-1:0]  o_x,
    input logic signed [pdp_pkg::COORD_W-1:0]  o_y,
    input logic [pdp_pkg::INDEX_W-1:0]         o_point_index,
    input logic                                o_list_full
);
    import pdp_pkg::*;

    localparam logic [INDEX_W-1:0] IdxFull = INDEX_W'((MAX_POINTS - 1) % 64);

    // A point waiting for transfer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_x) && $stable(o_y)
            && $stable(o_point_index) && $stable(o_list_full))
        else $error("point changed while stalled");

    // A byte offered but not taken is still offered, unchanged, in the next cycle.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_ch) && $stable(i_last))
        else $error("input byte changed while stalled");

    // Reset empties the point register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("point valid after reset");

    // A free output side never stalls the input side.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with free output");

    // The point that fills the list is always the last slot of the list.
    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_list_full |-> o_point_index == IdxFull)
        else $error("list full flagged on wrong index");

endmodule

bind path_data_point_parser pdp_checker #(.MAX_POINTS(MAX_POINTS)) u_pdp_checker (.*);
